// ===== hdl/clpf_pkg.sv =====
package clpf_pkg;

  localparam int CLPF_CELL_COLUMNS = 16;
  localparam int CLPF_CELL_ROWS    = 2;
  localparam int CLPF_GLYPH_SLOTS  = 8;

  localparam int CELL_W  = 5;
  localparam int CELL_H  = 8;
  localparam int GLYPH_W = CELL_W * CELL_H;

  typedef logic [GLYPH_W-1:0] glyph_t;

  typedef enum logic [2:0] {
    FN_DOT   = 3'd0,
    FN_HRUN  = 3'd1,
    FN_VRUN  = 3'd2,
    FN_CLEAR = 3'd3,
    FN_DRAW  = 3'd4
  } func_e;

  typedef enum logic {
    KIND_CLEAR = 1'b0,
    KIND_GLYPH = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_CLEAR,
    ST_CLR_OUT,
    ST_DRAW,
    ST_FLUSH
  } state_e;

  // start of a dot or run walk
  typedef struct packed {
    logic       vert;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic [7:0] run_length;
  } walk_cmd_t;

  typedef struct packed {
    logic busy;
    logic final_px;
  } walk_sts_t;

  // x / 5 for 0..255 via reciprocal multiply
  function automatic logic [5:0] div5(input logic [7:0] x);
    logic [15:0] p;
    p = {8'd0, x} * 16'd205;
    return p[15:10];
  endfunction

  // one-hot pixel bit inside a cell, leftmost pixel is the row msb
  function automatic glyph_t pixel_bit(input logic [2:0] ix, input logic [2:0] iy);
    logic [5:0] sh;
    sh = {3'b000, 3'd4 - ix} + {3'b000, iy} * 6'd5;
    return glyph_t'(1) << sh;
  endfunction

endpackage

// ===== hdl/clpf_ram.sv =====
module clpf_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/clpf_walk.sv =====
module clpf_walk
  import clpf_pkg::*;
#(
  parameter int CELL_COLUMNS = CLPF_CELL_COLUMNS,
  parameter int CELL_ROWS    = CLPF_CELL_ROWS,
  localparam int CELL_COUNT  = CELL_COLUMNS * CELL_ROWS,
  localparam int AW          = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  walk_cmd_t       cmd,
  output walk_sts_t       sts,
  output logic            req,
  output logic [AW-1:0]   addr,
  output glyph_t          mask
);

  localparam int CW = (CELL_COLUMNS > 1) ? $clog2(CELL_COLUMNS) : 1;
  localparam int RW = (CELL_ROWS > 1) ? $clog2(CELL_ROWS) : 1;
  localparam logic signed [9:0] PIX_W = 10'(CELL_COLUMNS * CELL_W);
  localparam logic signed [9:0] PIX_H = 10'(CELL_ROWS * CELL_H);

  logic [7:0]        count;
  logic              vert;
  logic signed [9:0] px;
  logic signed [9:0] py;
  logic [CW-1:0]     cx;
  logic [2:0]        ix;

  logic [5:0]        q5;
  logic [7:0]        r5;
  logic              in_range;
  logic [RW-1:0]     cy;

  assign q5 = div5(cmd.x_pos);
  assign r5 = cmd.x_pos - {2'b00, q5} * 8'd5;

  assign in_range = !px[9] && (px < PIX_W) && !py[9] && (py < PIX_H);
  assign cy       = py[RW+2:3];

  assign sts.busy     = (count != 8'd0);
  assign sts.final_px = (count == 8'd1);
  assign req          = sts.busy && in_range;
  assign addr         = AW'(cy * CELL_COLUMNS + cx);
  assign mask         = pixel_bit(ix, py[2:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 8'd0;
    end else if (start) begin
      count <= cmd.run_length;
    end else if (sts.busy) begin
      count <= count - 8'd1;
    end
  end

  // cell column tracked incrementally; stays at zero while x is negative
  always_ff @(posedge clk) begin
    if (start) begin
      vert <= cmd.vert;
      px   <= {{2{cmd.x_pos[7]}}, cmd.x_pos};
      py   <= {{2{cmd.y_pos[7]}}, cmd.y_pos};
      if (cmd.x_pos[7]) begin
        cx <= '0;
        ix <= 3'd0;
      end else begin
        cx <= CW'(q5);
        ix <= r5[2:0];
      end
    end else if (sts.busy) begin
      if (vert) begin
        py <= py + 10'sd1;
      end else begin
        px <= px + 10'sd1;
        if (!px[9]) begin
          if (ix == 3'd4) begin
            ix <= 3'd0;
            cx <= cx + CW'(1);
          end else begin
            ix <= ix + 3'd1;
          end
        end
      end
    end
  end

endmodule

// ===== hdl/clpf_rmw.sv =====
module clpf_rmw
  import clpf_pkg::*;
#(
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req,
  input  logic [AW-1:0] req_addr,
  input  glyph_t        req_mask,
  input  logic          clr_we,
  input  logic [AW-1:0] clr_addr,
  input  glyph_t        rd_data,
  output logic          we,
  output logic [AW-1:0] waddr,
  output glyph_t        wdata
);

  logic          s2_valid;
  logic [AW-1:0] s2_addr;
  glyph_t        s2_mask;
  logic          fwd_valid;
  logic [AW-1:0] fwd_addr;
  glyph_t        fwd_data;
  glyph_t        merged;

  // the ram reads old data when the previous cycle wrote the same cell
  assign merged = (fwd_valid && (fwd_addr == s2_addr)) ? fwd_data : rd_data;

  assign we    = s2_valid || clr_we;
  assign waddr = s2_valid ? s2_addr : clr_addr;
  assign wdata = s2_valid ? (merged | s2_mask) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      s2_valid  <= req;
      fwd_valid <= we;
    end
  end

  always_ff @(posedge clk) begin
    s2_addr  <= req_addr;
    s2_mask  <= req_mask;
    fwd_addr <= waddr;
    fwd_data <= wdata;
  end

endmodule

// ===== hdl/char_lcd_pixel_framebuffer_top.sv =====
// Pixel back-buffer for a character display of CELL_COLUMNS x CELL_ROWS cells of 5x8 pixels.
// Items come in on the s_ stream (tuser = operation, tdata = x, y, run length); results leave
// on the m_ stream (tuser = kind, tlast = final beat of the item). All cells live in one
// single-port-write, registered-read ram, updated by read-modify-write with a forward of the
// last write for back-to-back hits on the same cell. Items are handled one at a time: a dot or
// run does one ram read and write per pixel that falls on the display, a clear does one zero
// write per cell and then sends the clear beat, and a draw reads the cells row by row, one per
// cycle while the output does not stall, and stops early once all glyph slots are taken. After
// reset the block runs a clearing pass over all cells before it takes any item.
module char_lcd_pixel_framebuffer_top
  import clpf_pkg::*;
#(
  parameter int CELL_COLUMNS = CLPF_CELL_COLUMNS,
  parameter int CELL_ROWS    = CLPF_CELL_ROWS,
  parameter int GLYPH_SLOTS  = CLPF_GLYPH_SLOTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // x_pos[7:0], y_pos[15:8], run_length[23:16]
  input  logic [2:0]  s_tuser,   // func[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // slot[2:0], cell_col[6:3], cell_row[7], glyph[47:8]
  output logic        m_tuser,   // kind[0]
  output logic        m_tlast
);

  localparam int CELL_COUNT = CELL_COLUMNS * CELL_ROWS;
  localparam int AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int CW = (CELL_COLUMNS > 1) ? $clog2(CELL_COLUMNS) : 1;
  localparam int RW = (CELL_ROWS > 1) ? $clog2(CELL_ROWS) : 1;
  localparam int SW = $clog2(GLYPH_SLOTS + 1);

  state_e state, state_next;

  // input beat
  func_e      func;
  logic       accept;
  walk_cmd_t  walk_cmd;
  logic       walk_start;
  walk_sts_t  walk_sts;
  logic       walk_req;
  logic [AW-1:0] walk_addr;
  glyph_t     walk_mask;

  // ram ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  glyph_t        ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  glyph_t        ram_rdata;

  // clearing pass
  logic [AW-1:0] clr_addr;
  logic          clr_emit;
  logic          clr_we;
  logic          clr_done;

  // draw scan
  logic [CW-1:0] scan_col;
  logic [RW-1:0] scan_row;
  logic [AW-1:0] scan_addr;
  logic          scan_left;
  logic          scan_issue;
  logic [SW-1:0] found;
  logic          slots_full;
  logic          d2_valid;
  logic [CW-1:0] d2_col;
  logic [RW-1:0] d2_row;
  logic          take;
  logic          stall;

  // glyph held back until we know whether it is the last one
  logic          pend_valid;
  logic [2:0]    pend_slot;
  logic [3:0]    pend_col;
  logic          pend_row;
  glyph_t        pend_glyph;

  // output register
  logic          out_free;
  logic          load_push;
  logic          load_flush;
  logic          load_clear;
  logic          out_kind;
  logic [2:0]    out_slot;
  logic [3:0]    out_col;
  logic          out_row;
  glyph_t        out_glyph;
  logic          out_last;

  assign func     = func_e'(s_tuser);
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // a dot is a run of one pixel
  assign walk_cmd.vert       = (func == FN_VRUN);
  assign walk_cmd.x_pos      = s_tdata[7:0];
  assign walk_cmd.y_pos      = s_tdata[15:8];
  assign walk_cmd.run_length = (func == FN_DOT) ? 8'd1 : s_tdata[23:16];
  assign walk_start = accept && ((func == FN_DOT) || (func == FN_HRUN) || (func == FN_VRUN));

  clpf_walk #(
    .CELL_COLUMNS (CELL_COLUMNS),
    .CELL_ROWS    (CELL_ROWS)
  ) u_walk (
    .clk   (clk),
    .rst   (rst),
    .start (walk_start),
    .cmd   (walk_cmd),
    .sts   (walk_sts),
    .req   (walk_req),
    .addr  (walk_addr),
    .mask  (walk_mask)
  );

  clpf_rmw #(
    .DEPTH (CELL_COUNT)
  ) u_rmw (
    .clk      (clk),
    .rst      (rst),
    .req      (walk_req),
    .req_addr (walk_addr),
    .req_mask (walk_mask),
    .clr_we   (clr_we),
    .clr_addr (clr_addr),
    .rd_data  (ram_rdata),
    .we       (ram_we),
    .waddr    (ram_waddr),
    .wdata    (ram_wdata)
  );

  // walk and scan never run together
  assign scan_addr = AW'(scan_row * CELL_COLUMNS + scan_col);
  assign ram_re    = walk_req || scan_issue;
  assign ram_raddr = walk_req ? walk_addr : scan_addr;

  clpf_ram #(
    .WIDTH (GLYPH_W),
    .DEPTH (CELL_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign clr_done   = (clr_addr == AW'(CELL_COUNT - 1));
  assign out_free   = !m_tvalid || m_tready;
  assign slots_full = (found == SW'(GLYPH_SLOTS));
  // a non-empty cell came back from the ram and there is still a slot for it
  assign take       = d2_valid && (ram_rdata != '0) && !slots_full;
  // the held glyph has to move out first; ram data stays put while stalled
  assign stall      = take && pend_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    clr_we     = 1'b0;
    scan_issue = 1'b0;
    load_push  = 1'b0;
    load_flush = 1'b0;
    load_clear = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (func) inside
            FN_DOT, FN_HRUN, FN_VRUN: state_next = ST_WALK;
            FN_CLEAR:                 state_next = ST_CLEAR;
            FN_DRAW:                  state_next = ST_DRAW;
            default:                  state_next = ST_IDLE;
          endcase
        end
      end
      ST_WALK: begin
        if (!walk_sts.busy || walk_sts.final_px) begin
          state_next = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        clr_we = 1'b1;
        if (clr_done) begin
          state_next = clr_emit ? ST_CLR_OUT : ST_IDLE;
        end
      end
      ST_CLR_OUT: begin
        if (out_free) begin
          load_clear = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_DRAW: begin
        scan_issue = scan_left && !slots_full && !stall;
        load_push  = take && pend_valid && out_free;
        if ((!scan_left || slots_full) && !d2_valid) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          load_flush = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // clearing pass: once after reset, and for every clear item
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      clr_emit <= 1'b0;
    end else if (accept && (func == FN_CLEAR)) begin
      clr_addr <= '0;
      clr_emit <= 1'b1;
    end else if (clr_we && !clr_done) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // draw scan, one cell read per cycle while not stalled, row by row
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_left  <= 1'b0;
      d2_valid   <= 1'b0;
      pend_valid <= 1'b0;
      found      <= '0;
    end else if (accept && (func == FN_DRAW)) begin
      scan_left  <= 1'b1;
      d2_valid   <= 1'b0;
      pend_valid <= 1'b0;
      found      <= '0;
    end else if (state == ST_DRAW) begin
      if (!stall) begin
        d2_valid <= scan_issue;
        if (scan_issue && (scan_col == CW'(CELL_COLUMNS - 1)) &&
            (scan_row == RW'(CELL_ROWS - 1))) begin
          scan_left <= 1'b0;
        end
        if (take) begin
          pend_valid <= 1'b1;
          found      <= found + SW'(1);
        end
      end
    end else if (load_flush) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (func == FN_DRAW)) begin
      scan_col <= '0;
      scan_row <= '0;
    end else if (scan_issue) begin
      if (scan_col == CW'(CELL_COLUMNS - 1)) begin
        scan_col <= '0;
        scan_row <= scan_row + RW'(1);
      end else begin
        scan_col <= scan_col + CW'(1);
      end
    end
    if ((state == ST_DRAW) && !stall) begin
      d2_col <= scan_col;
      d2_row <= scan_row;
    end
    if ((state == ST_DRAW) && take && !stall) begin
      pend_slot  <= 3'(found);
      pend_col   <= 4'(d2_col);
      pend_row   <= 1'(d2_row);
      pend_glyph <= ram_rdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_push || load_flush || load_clear) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_push || load_flush) begin
      out_kind  <= KIND_GLYPH;
      out_slot  <= pend_slot;
      out_col   <= pend_col;
      out_row   <= pend_row;
      out_glyph <= pend_glyph;
      out_last  <= load_flush;
    end else if (load_clear) begin
      out_kind  <= KIND_CLEAR;
      out_slot  <= 3'd0;
      out_col   <= 4'd0;
      out_row   <= 1'b0;
      out_glyph <= '0;
      out_last  <= 1'b1;
    end
  end

  assign m_tdata = {out_glyph, out_row, out_col, out_slot};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

endmodule

// ===== hdl/clpf_checker.sv =====
module clpf_checker
  import clpf_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  logic [2:0] exp_slot;

  // glyph slots count up from zero within one draw
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_slot <= 3'd0;
    end else if (m_tvalid && m_tready && (m_tuser == KIND_GLYPH)) begin
      exp_slot <= m_tlast ? 3'd0 : (m_tdata[2:0] + 3'd1);
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output beat changed while stalled");

  a_clear_beat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_CLEAR) |-> m_tlast && (m_tdata == 48'd0))
    else $error("clear beat carries data or lacks last");

  a_glyph_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_GLYPH) |-> (m_tdata[47:8] != 40'd0))
    else $error("empty cell emitted as glyph");

  a_slot_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_GLYPH) |-> (m_tdata[2:0] == exp_slot))
    else $error("glyph slot out of order");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input taken during clearing pass");

endmodule

bind char_lcd_pixel_framebuffer_top clpf_checker u_clpf_checker (.*);
